/* src/b64sd_pkg.sv */
package b64sd_pkg;

    // Result queue: worst case one character yields three entries
    // (a full group, or a three-sextet flush followed by the end entry).
    localparam int FIFO_DEPTH    = 4;
    localparam int PTR_W         = 2;
    localparam int CNT_W         = 3;
    localparam int MAX_PER_CHAR  = 3;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        out_last;
        logic        status;
        logic [15:0] total_bytes;
    } b64sd_item_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } b64sd_sextet_t;

    // Alphabet lookup: A-Z a-z 0-9 + /
    function automatic b64sd_sextet_t sextet_of(input logic [7:0] c);
        b64sd_sextet_t r;
        r.valid = 1'b1;
        r.value = 6'd0;
        if (c inside {[8'h41:8'h5A]})
        begin
            r.value = 6'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            r.value = 6'(c - 8'd71);
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            r.value = 6'(c + 8'd4);
        end
        else if (c == CHAR_PLUS)
        begin
            r.value = 6'd62;
        end
        else if (c == CHAR_SLASH)
        begin
            r.value = 6'd63;
        end
        else
        begin
            r.valid = 1'b0;
        end
        return r;
    endfunction

endpackage

/* src/base64_stream_decoder.sv */
// Streaming base64 decoder, standard alphabet (A-Z a-z 0-9 + /). One
// character enters per s_* transaction; every fourth valid character
// releases three decoded bytes on m_*. A '=' or a NUL in the middle of a
// group flushes the partial group (1 byte for one or two sextets held, 2
// bytes for three, missing sextets read as zero). After '=' or an invalid
// character the rest of the string is ignored until NUL. NUL closes the
// string with an end transaction (m_tlast high, m_tuser low) that carries
// the status (1 = invalid character seen, discard the bytes) and the
// decoded byte count saturating at 65535, then the decoder returns to its
// reset state. Rate: the decode for a character is done in the cycle it is
// accepted and its results land in a four-entry result queue, visible on
// m_* from the next cycle; the output drains one transaction per cycle while
// m_tready is high. A character is accepted whenever at most one result is
// still queued. A character that queues three results (a full group, or a
// NUL after three held sextets) or two results holds s_tready low until the
// queue has drained to one entry, so a steady run of valid characters is
// held back after each full group; stalls on m_tready add to that.
module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [8] status,
                                   // [24:9] total_bytes, [31:25] zero
    output logic        m_tuser,   // [0] byte_valid
    output logic        m_tlast    // out_last
);

    // Decoder state
    logic [1:0]   pos_reg, pos_next;          // sextets held in the group
    logic [17:0]  held_reg, held_next;        // held sextets, newest low
    logic         stopped_reg, stopped_next;  // after '=' or invalid char
    logic         error_reg, error_next;
    logic [15:0]  count_reg, count_next;      // decoded bytes, saturating

    // Result queue
    b64sd_item_t  fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg, fill_next;

    logic          s_accept;
    logic          m_accept;
    b64sd_sextet_t sx;
    logic          is_nul;
    logic          is_pad;
    logic [1:0]    flush_bytes;
    logic [1:0]    n_bytes;
    logic [CNT_W-1:0] n_wr;
    logic [7:0]    byte_val [MAX_PER_CHAR];
    b64sd_item_t   wr_item [MAX_PER_CHAR];
    logic [16:0]   count_sum;
    logic [15:0]   count_sat;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    // Room for the worst case of three new entries
    assign s_tready = (fill_reg <= CNT_W'(FIFO_DEPTH - MAX_PER_CHAR));

    assign sx     = sextet_of(s_tdata);
    assign is_nul = (s_tdata == CHAR_NUL);
    assign is_pad = (s_tdata == CHAR_PAD);

    // Bytes a partial-group flush produces
    always_comb
    begin
        case (pos_reg)
            2'd0:    flush_bytes = 2'd0;
            2'd3:    flush_bytes = 2'd2;
            default: flush_bytes = 2'd1;
        endcase
    end

    // Next state and the bytes this character releases
    always_comb
    begin
        pos_next     = pos_reg;
        held_next    = held_reg;
        stopped_next = stopped_reg;
        error_next   = error_reg;
        n_bytes      = 2'd0;
        byte_val[0]  = 8'd0;
        byte_val[1]  = 8'd0;
        byte_val[2]  = 8'd0;

        // Partial-group bytes, used on '=' and NUL
        case (pos_reg)
            2'd1:    byte_val[0] = {held_reg[5:0], 2'b00};
            2'd2:    byte_val[0] = held_reg[11:4];
            2'd3:
            begin
                byte_val[0] = held_reg[17:10];
                byte_val[1] = held_reg[9:2];
            end
            default: byte_val[0] = 8'd0;
        endcase

        if (is_nul)
        begin
            n_bytes      = stopped_reg ? 2'd0 : flush_bytes;
            pos_next     = 2'd0;
            held_next    = '0;
            stopped_next = 1'b0;
            error_next   = 1'b0;
        end
        else if (stopped_reg)
        begin
            n_bytes = 2'd0;
        end
        else if (is_pad)
        begin
            n_bytes      = flush_bytes;
            stopped_next = 1'b1;
            pos_next     = 2'd0;
            held_next    = '0;
        end
        else if (!sx.valid)
        begin
            error_next   = 1'b1;
            stopped_next = 1'b1;
            pos_next     = 2'd0;
            held_next    = '0;
        end
        else if (pos_reg == 2'd3)
        begin
            // Fourth sextet completes the group
            n_bytes     = 2'd3;
            byte_val[0] = held_reg[17:10];
            byte_val[1] = held_reg[9:2];
            byte_val[2] = {held_reg[1:0], sx.value};
            pos_next    = 2'd0;
            held_next   = '0;
        end
        else
        begin
            held_next = {held_reg[11:0], sx.value};
            pos_next  = pos_reg + 2'd1;
        end
    end

    // Saturating byte count; the end entry reports the count after the flush
    assign count_sum = {1'b0, count_reg} + 17'(n_bytes);
    assign count_sat = count_sum[16] ? COUNT_MAX : count_sum[15:0];
    assign count_next = is_nul ? 16'd0 : count_sat;

    // Queue entries: the bytes, then the end entry on NUL
    always_comb
    begin
        for (int i = 0; i < MAX_PER_CHAR; i++)
        begin
            wr_item[i].out_byte    = byte_val[i];
            wr_item[i].byte_valid  = 1'b1;
            wr_item[i].out_last    = 1'b0;
            wr_item[i].status      = 1'b0;
            wr_item[i].total_bytes = 16'd0;
            if (2'(i) == n_bytes)
            begin
                wr_item[i].out_byte    = 8'd0;
                wr_item[i].byte_valid  = 1'b0;
                wr_item[i].out_last    = 1'b1;
                wr_item[i].status      = error_reg;
                wr_item[i].total_bytes = count_sat;
            end
        end
    end

    assign n_wr = s_accept ? (CNT_W'(n_bytes) + CNT_W'(is_nul)) : '0;
    assign fill_next = fill_reg + n_wr - CNT_W'(m_accept);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            held_reg    <= '0;
            stopped_reg <= 1'b0;
            error_reg   <= 1'b0;
            count_reg   <= '0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            fill_reg    <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                pos_reg     <= pos_next;
                held_reg    <= held_next;
                stopped_reg <= stopped_next;
                error_reg   <= error_next;
                count_reg   <= count_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(n_wr);
            if (m_accept)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    // Queue storage, payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PER_CHAR; i++)
        begin
            if (CNT_W'(i) < n_wr)
            begin
                fifo_reg[wr_ptr_reg + PTR_W'(i)] <= wr_item[i];
            end
        end
    end

    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {7'd0, fifo_reg[rd_ptr_reg].total_bytes,
                       fifo_reg[rd_ptr_reg].status, fifo_reg[rd_ptr_reg].out_byte};
    assign m_tuser  = fifo_reg[rd_ptr_reg].byte_valid;
    assign m_tlast  = fifo_reg[rd_ptr_reg].out_last;

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_nul_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && s_tdata == CHAR_NUL) |=> (fill_reg != '0))
        else $error("NUL accepted without end transaction queued");

    a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> (pos_reg == 2'd0 && held_reg == '0))
        else $error("group held while stopped");

    a_err_stops: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> stopped_reg)
        else $error("error flag without stop");

endmodule
